// File: rtl/core/jcfs_pkg.sv
// Package for the jet cone flavour selector: fixed-point constants, code ranges
// of the particle families, class and register codes, and the flag struct.
// Depends on nothing; used by jcfs_cone_eval and jet_cone_flavour_select.
package jcfs_pkg;

  localparam int FRAC_BITS = 12;
  localparam int MAX_PARTICLES_DEF = 65536;

  localparam longint PI_Q32 = 64'sd13493037705;
  localparam longint PI_FX_L = (PI_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
  localparam int PHI_W = 20;
  localparam logic signed [PHI_W-1:0] PI_FX = PHI_W'(PI_FX_L);
  localparam logic signed [PHI_W-1:0] TWO_PI_FX = PHI_W'(2 * PI_FX_L);

  localparam logic [24:0] CODE_GLUON = 25'd21;
  localparam logic [24:0] QUARK_MIN = 25'd1;
  localparam logic [24:0] QUARK_MAX = 25'd5;
  localparam logic [24:0] CODE_B_QUARK = 25'd5;
  localparam logic [24:0] CODE_C_QUARK = 25'd4;
  localparam logic [24:0] HAD_LO = 25'd400;
  localparam logic [24:0] HAD_MID = 25'd500;
  localparam logic [24:0] HAD_HI = 25'd600;
  localparam logic [24:0] HAD2_LO = 25'd4000;
  localparam logic [24:0] HAD2_MID = 25'd5000;
  localparam logic [24:0] HAD2_HI = 25'd6000;

  localparam logic [33:0] CONE_RADIUS_SQ_RST = 34'd8220835;

  typedef enum logic [1:0] {
    CLASS_BEAUTY = 2'd0,
    CLASS_CHARM  = 2'd1,
    CLASS_LEAD   = 2'd2
  } cls_t;

  typedef enum logic {
    MODE_PARTON = 1'b0,
    MODE_HADRON = 1'b1
  } mode_t;

  typedef enum logic {
    REG_CLASS_MODE  = 1'b0,
    REG_CONE_RADIUS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic elig;
    logic beauty;
    logic charm;
  } kind_t;

endpackage

// File: rtl/core/jet_cone_flavour_select.sv
// Top level of the jet cone flavour selector: input register, cone check
// stage, run state and result register, and the configuration registers.
// Depends on jcfs_pkg and jcfs_cone_eval.
//
// Each input item is one particle slot of a jet together with the jet axis;
// last_item closes the jet's run. An item is accepted when in_valid and
// in_ready are both high, and a result item leaves when out_valid and
// out_ready are both high. A beauty particle inside the cone gives a result at
// once and the rest of the run gives none; otherwise the last item gives the
// first in-cone charm particle, else the leading in-cone pt, else not found.
// One item is accepted per cycle while in_ready is high. An item passes the
// input register and the squaring register, and the run-state stage then
// writes its result into the output register. The run state is updated once
// per item, which sets the rate of one item per clock unless stalled. When the output
// register holds an untaken result, only an item that must deliver a result
// waits in the last stage; items that give none keep flowing, and in_ready
// falls only once the stages before it are full. At reset the pipeline is
// empty, the run state is cleared, class_mode is 0 and cone_radius_sq is 0.49.
module jet_cone_flavour_select #(
  parameter int MAX_PARTICLES = jcfs_pkg::MAX_PARTICLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_jet_eta,
  input  logic signed [15:0] in_jet_phi,
  input  logic               in_particle_present,
  input  logic signed [24:0] in_particle_code,
  input  logic signed [15:0] in_particle_eta,
  input  logic signed [15:0] in_particle_phi,
  input  logic [19:0]        in_particle_pt,
  input  logic               in_last_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic [15:0]        out_chosen_index,
  output logic signed [24:0] out_chosen_code,
  output logic [1:0]         out_chosen_class,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import jcfs_pkg::*;

  localparam int CW = $clog2(MAX_PARTICLES + 1);

  mode_t       class_mode_r;
  logic [33:0] cone_radius_sq_r;
  reg_idx_t    reg_idx;

  logic               v1_r;
  logic signed [15:0] jet_eta_r;
  logic signed [15:0] jet_phi_r;
  logic               present1_r;
  logic signed [24:0] code1_r;
  logic signed [15:0] peta_r;
  logic signed [15:0] pphi_r;
  logic [19:0]        pt1_r;
  logic               last1_r;

  logic [31:0] eta_sq;
  logic [31:0] phi_sq;
  kind_t       kind;

  logic               v2_r;
  logic [31:0]        eta_sq_r;
  logic [31:0]        phi_sq_r;
  kind_t              kind_r;
  logic               present2_r;
  logic signed [24:0] code2_r;
  logic [19:0]        pt2_r;
  logic               last2_r;

  logic [CW-1:0]      cnt_r;
  logic               run_done_r;
  logic [19:0]        best_pt_r;
  logic [15:0]        best_index_r;
  logic signed [24:0] best_code_r;
  logic               charm_seen_r;
  logic [15:0]        charm_index_r;
  logic signed [24:0] charm_code_r;

  logic [CW-1:0]      cnt_nxt;
  logic               run_done_nxt;
  logic [19:0]        best_pt_nxt;
  logic [15:0]        best_index_nxt;
  logic signed [24:0] best_code_nxt;
  logic               charm_seen_nxt;
  logic [15:0]        charm_index_nxt;
  logic signed [24:0] charm_code_nxt;

  logic               in_cone;
  logic               hit;
  logic               beauty_hit;
  logic               emit;
  logic [15:0]        pos16;
  logic               res_found;
  logic [15:0]        res_index;
  logic signed [24:0] res_code;
  cls_t               res_class;

  logic s1_ready;
  logic s2_ready;
  logic s2_fire;

  logic               out_valid_r;
  logic               found_r;
  logic [15:0]        index_r;
  logic signed [24:0] code_r;
  cls_t               class_r;

  assign reg_idx = reg_idx_t'(paddr[3]);
  assign pready = 1'b1;

  always_comb begin
    case (reg_idx)
      REG_CLASS_MODE:  prdata = {63'd0, class_mode_r};
      REG_CONE_RADIUS: prdata = {30'd0, cone_radius_sq_r};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_mode_r <= MODE_PARTON;
      cone_radius_sq_r <= CONE_RADIUS_SQ_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_CLASS_MODE:  class_mode_r <= mode_t'(pwdata[0]);
        REG_CONE_RADIUS: cone_radius_sq_r <= pwdata[33:0];
        default: begin
        end
      endcase
    end
  end

  assign s1_ready = !v1_r || s2_ready;
  assign in_ready = s1_ready;
  assign s2_ready = !v2_r || s2_fire;
  assign s2_fire = v2_r && (!emit || !out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (s1_ready) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      jet_eta_r <= in_jet_eta;
      jet_phi_r <= in_jet_phi;
      present1_r <= in_particle_present;
      code1_r <= in_particle_code;
      peta_r <= in_particle_eta;
      pphi_r <= in_particle_phi;
      pt1_r <= in_particle_pt;
      last1_r <= in_last_item;
    end
  end

  jcfs_cone_eval u_eval (
    .jet_eta       (jet_eta_r),
    .jet_phi       (jet_phi_r),
    .particle_code (code1_r),
    .particle_eta  (peta_r),
    .particle_phi  (pphi_r),
    .class_mode    (class_mode_r),
    .eta_sq        (eta_sq),
    .phi_sq        (phi_sq),
    .kind          (kind)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (s2_ready) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r && s2_ready) begin
      eta_sq_r <= eta_sq;
      phi_sq_r <= phi_sq;
      kind_r <= kind;
      present2_r <= present1_r;
      code2_r <= code1_r;
      pt2_r <= pt1_r;
      last2_r <= last1_r;
    end
  end

  always_comb begin
    in_cone = ({1'b0, 33'(eta_sq_r) + 33'(phi_sq_r)} < cone_radius_sq_r);
    pos16 = 16'(cnt_r);
    hit = !run_done_r && present2_r && (cnt_r < CW'(MAX_PARTICLES)) && kind_r.elig && in_cone;
    beauty_hit = hit && kind_r.beauty;

    cnt_nxt = (cnt_r < CW'(MAX_PARTICLES)) ? cnt_r + CW'(1) : cnt_r;
    run_done_nxt = run_done_r || beauty_hit;
    charm_seen_nxt = charm_seen_r;
    charm_index_nxt = charm_index_r;
    charm_code_nxt = charm_code_r;
    best_pt_nxt = best_pt_r;
    best_index_nxt = best_index_r;
    best_code_nxt = best_code_r;
    if (hit && !kind_r.beauty) begin
      if (kind_r.charm && !charm_seen_r) begin
        charm_seen_nxt = 1'b1;
        charm_index_nxt = pos16;
        charm_code_nxt = code2_r;
      end
      if (pt2_r > best_pt_r) begin
        best_pt_nxt = pt2_r;
        best_index_nxt = pos16;
        best_code_nxt = code2_r;
      end
    end

    emit = beauty_hit || (last2_r && !run_done_r);
    if (beauty_hit) begin
      res_found = 1'b1;
      res_index = pos16;
      res_code = code2_r;
      res_class = CLASS_BEAUTY;
    end else if (charm_seen_nxt) begin
      res_found = 1'b1;
      res_index = charm_index_nxt;
      res_code = charm_code_nxt;
      res_class = CLASS_CHARM;
    end else if (best_pt_nxt != 20'd0) begin
      res_found = 1'b1;
      res_index = best_index_nxt;
      res_code = best_code_nxt;
      res_class = CLASS_LEAD;
    end else begin
      res_found = 1'b0;
      res_index = '0;
      res_code = '0;
      res_class = CLASS_BEAUTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      run_done_r <= 1'b0;
      best_pt_r <= '0;
      charm_seen_r <= 1'b0;
    end else if (s2_fire) begin
      if (last2_r) begin
        cnt_r <= '0;
        run_done_r <= 1'b0;
        best_pt_r <= '0;
        charm_seen_r <= 1'b0;
      end else begin
        cnt_r <= cnt_nxt;
        run_done_r <= run_done_nxt;
        best_pt_r <= best_pt_nxt;
        charm_seen_r <= charm_seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      best_index_r <= best_index_nxt;
      best_code_r <= best_code_nxt;
      charm_index_r <= charm_index_nxt;
      charm_code_r <= charm_code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (out_valid_r && !out_ready) || (s2_fire && emit);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && emit) begin
      found_r <= res_found;
      index_r <= res_index;
      code_r <= res_code;
      class_r <= res_class;
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = found_r;
  assign out_chosen_index = index_r;
  assign out_chosen_code = code_r;
  assign out_chosen_class = class_r;

endmodule

// File: rtl/core/jcfs_cone_eval.sv
// Geometry and family check for one particle: wrapped phi difference, squared
// eta and phi distances, and the eligible, beauty and charm flags.
// Depends on jcfs_pkg.
module jcfs_cone_eval (
  input  logic signed [15:0] jet_eta,
  input  logic signed [15:0] jet_phi,
  input  logic signed [24:0] particle_code,
  input  logic signed [15:0] particle_eta,
  input  logic signed [15:0] particle_phi,
  input  jcfs_pkg::mode_t    class_mode,
  output logic [31:0]        eta_sq,
  output logic [31:0]        phi_sq,
  output jcfs_pkg::kind_t    kind
);
  import jcfs_pkg::*;

  function automatic logic signed [PHI_W-1:0] wrap_phi(input logic signed [PHI_W-1:0] p);
    logic signed [PHI_W-1:0] r;
    r = p;
    if (p < -PI_FX) begin
      r = p + TWO_PI_FX;
    end else if (p > PI_FX) begin
      r = p - TWO_PI_FX;
    end
    return r;
  endfunction

  logic signed [16:0]      deta;
  logic signed [PHI_W-1:0] dphi;
  logic [15:0]             deta_mag;
  logic [15:0]             dphi_mag;
  logic [24:0]             code_mag;

  always_comb begin
    deta = 17'(jet_eta) - 17'(particle_eta);
    dphi = wrap_phi(wrap_phi(PHI_W'(jet_phi)) - wrap_phi(PHI_W'(particle_phi)));
    deta_mag = deta[16] ? 16'(-deta) : 16'(deta);
    dphi_mag = dphi[PHI_W-1] ? 16'(-dphi) : 16'(dphi);
    eta_sq = 32'(deta_mag) * 32'(deta_mag);
    phi_sq = 32'(dphi_mag) * 32'(dphi_mag);
    code_mag = particle_code[24] ? 25'(-particle_code) : 25'(particle_code);
  end

  always_comb begin
    case (class_mode)
      MODE_PARTON: begin
        kind.elig   = (code_mag inside {[QUARK_MIN:QUARK_MAX], CODE_GLUON});
        kind.beauty = (code_mag == CODE_B_QUARK);
        kind.charm  = (code_mag == CODE_C_QUARK);
      end
      MODE_HADRON: begin
        kind.elig   = (code_mag inside {[HAD_LO:HAD_HI], [HAD2_LO:HAD2_HI]});
        kind.beauty = (code_mag inside {[HAD_MID:HAD_HI], [HAD2_MID:HAD2_HI]});
        kind.charm  = (code_mag inside {[HAD_LO:HAD_MID], [HAD2_LO:HAD2_MID]});
      end
      default: begin
        kind = '0;
      end
    endcase
  end

endmodule
